### sv/flap_high_speed_mode_command_filter_assert.svh
// Assertion macros for the flap high-speed mode command filter.
// Included by the top level; no other dependencies.
`ifndef FLAP_HIGH_SPEED_MODE_COMMAND_FILTER_ASSERT_SVH
`define FLAP_HIGH_SPEED_MODE_COMMAND_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define FHSM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FHSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fhsm_pkg.sv
// Shared types and constants for the flap high-speed mode command filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package fhsm_pkg;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] POS_CLOSE     = 3'd0;
    localparam logic [2:0] POS_OPEN1     = 3'd1;
    localparam logic [2:0] POS_OPEN      = 3'd3;
    localparam logic [2:0] POS_DIAG_AUTO = 3'd6;
    localparam logic [2:0] POS_UNKNOWN   = 3'd7;

    localparam logic [7:0] UNIT_A_MASK = 8'h07;
    localparam logic [7:0] UNIT_B_MASK = 8'h38;
    localparam int         UNIT_B_SHIFT = 3;

    localparam logic [1:0] UNIT_ONE   = 2'd0;
    localparam logic [1:0] UNIT_TWO   = 2'd1;
    localparam logic [1:0] UNIT_THREE = 2'd2;
    localparam logic [1:0] UNIT_NONE  = 2'd3;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTER_SPEED = 3'd0,
        REG_EXIT_SPEED  = 3'd1,
        REG_EXIT_DELAY  = 3'd2,
        REG_SPEED_ERROR = 3'd3,
        REG_HS_ENABLE   = 3'd4,
        REG_UNIT_SELECT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  enter_speed_kph;
        logic [7:0]  exit_speed_kph;
        logic [15:0] exit_delay_ms;
        logic [7:0]  speed_error_code;
        logic        high_speed_enable;
        logic [1:0]  unit_select;
    } cfg_t;

    // first declared member sits in the top bits
    typedef struct packed {
        logic [1:0] pad;
        logic       action_is_auto_diag;
        logic [2:0] current_position;
        logic       motion_stopped;
        logic       init_busy;
        logic [7:0] target_byte_b;
        logic [7:0] target_byte_a;
        logic [7:0] speed_raw;
    } in_item_t;

    typedef struct packed {
        logic [5:0] pad;
        logic       diag_mark;
        logic [2:0] reported_pos;
        logic       step_start;
        logic [2:0] motion_command;
        logic [7:0] speed_kph;
        logic       exit_waiting;
        logic       high_speed_mode;
    } result_t;

    typedef struct packed {
        logic        mode_high;
        logic        exit_armed;
        logic [15:0] exit_timer;
    } mode_state_t;

    typedef struct packed {
        logic [2:0] effective_cmd;
        logic [2:0] requested_cmd;
        logic       diag_flag;
    } cmd_state_t;

endpackage

`default_nettype wire

### sv/flap_high_speed_mode_command_filter.sv
// Flap high-speed mode command filter: accepts one item (data frame or 1 ms tick) per
// clock cycle unless stalled; the result is presented on the master side from the result
// register and held until taken. An item is captured in an input register, passes one
// stage of compare and select logic against the mode and command state, and lands in a
// result register; a stall on the master side holds the result while one more item waits
// in the input register, so the sustained rate is one item per cycle whenever the master
// side takes one per cycle. Configuration writes take effect at the next clock edge; the
// user must make them only while the block is idle, which the block does not enforce.
// Depends on fhsm_pkg, fhsm_mode_ctrl, fhsm_cmd_filter and the assertion header.
`default_nettype none

`include "flap_high_speed_mode_command_filter_assert.svh"

module flap_high_speed_mode_command_filter (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wr_en,
    input  wire logic [fhsm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fhsm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // speed_raw, target_byte_a, target_byte_b, init_busy, motion_stopped,
    // current_position, action_is_auto_diag, zero fill
    input  wire logic [fhsm_pkg::IN_DATA_W-1:0]  s_tdata,
    // command
    input  wire logic [fhsm_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // high_speed_mode, exit_waiting, speed_kph, motion_command, step_start,
    // reported_pos, diag_mark, zero fill
    output logic [fhsm_pkg::OUT_DATA_W-1:0]      m_tdata
);
    import fhsm_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        in_cmd_reg;
    logic        out_valid_reg;
    result_t     out_data_reg;
    mode_state_t mode_reg;
    mode_state_t mode_next;
    cmd_state_t  cmd_reg;
    cmd_state_t  cmd_next;
    logic [7:0]  last_speed_reg;
    logic [7:0]  last_speed_next;
    logic [7:0]  speed_kph;
    logic        is_frame;
    logic        advance;
    logic        step_start;
    logic [2:0]  reported_pos;
    result_t     result;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign is_frame = (in_cmd_reg == CMD_FRAME);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enter_speed_kph   <= 8'd140;
            cfg_reg.exit_speed_kph    <= 8'd135;
            cfg_reg.exit_delay_ms     <= 16'd10000;
            cfg_reg.speed_error_code  <= 8'd255;
            cfg_reg.high_speed_enable <= 1'b1;
            cfg_reg.unit_select       <= UNIT_ONE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ENTER_SPEED: cfg_reg.enter_speed_kph   <= cfg_data[7:0];
                REG_EXIT_SPEED:  cfg_reg.exit_speed_kph    <= cfg_data[7:0];
                REG_EXIT_DELAY:  cfg_reg.exit_delay_ms     <= cfg_data[15:0];
                REG_SPEED_ERROR: cfg_reg.speed_error_code  <= cfg_data[7:0];
                REG_HS_ENABLE:   cfg_reg.high_speed_enable <= cfg_data[0];
                REG_UNIT_SELECT: cfg_reg.unit_select       <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    fhsm_mode_ctrl u_mode (
        .cfg         (cfg_reg),
        .is_frame    (is_frame),
        .speed_raw   (in_item_reg.speed_raw),
        .cur         (mode_reg),
        .nxt         (mode_next),
        .speed_kph   (speed_kph)
    );

    fhsm_cmd_filter u_filter (
        .cfg             (cfg_reg),
        .is_frame        (is_frame),
        .item            (in_item_reg),
        .mode            (mode_next),
        .cur             (cmd_reg),
        .nxt             (cmd_next),
        .step_start      (step_start),
        .reported_pos    (reported_pos)
    );

    assign last_speed_next = is_frame ? speed_kph : last_speed_reg;

    always_comb
    begin
        result                 = '0;
        result.high_speed_mode = mode_next.mode_high;
        result.exit_waiting    = cfg_reg.high_speed_enable && mode_next.mode_high
                              && mode_next.exit_armed;
        result.speed_kph       = last_speed_next;
        result.motion_command  = cmd_next.effective_cmd;
        result.step_start      = step_start;
        result.reported_pos    = reported_pos;
        result.diag_mark       = cmd_next.diag_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= '0;
            last_speed_reg <= 8'd0;
            cmd_reg        <= '{effective_cmd: POS_UNKNOWN, requested_cmd: POS_UNKNOWN,
                                diag_flag: 1'b0};
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                mode_reg       <= mode_next;
                last_speed_reg <= last_speed_next;
                cmd_reg        <= cmd_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item_t'(s_tdata);
            in_cmd_reg  <= s_tuser[0];
        end
        if (advance)
            out_data_reg <= result;
    end

    `FHSM_ASSERT_IMPLIES(a_timer_needs_arm, clk, rst_n, mode_reg.exit_timer != 16'd0,
        mode_reg.exit_armed, "exit timer nonzero while exit not armed")

    `FHSM_ASSERT_IMPLIES(a_wait_in_high, clk, rst_n, out_valid_reg && out_data_reg.exit_waiting,
        out_data_reg.high_speed_mode, "exit_waiting reported outside high-speed mode")

    `FHSM_ASSERT_NEXT(a_tick_no_step, clk, rst_n, advance && (in_cmd_reg == CMD_TICK),
        !out_data_reg.step_start, "step_start raised for a tick item")

    `FHSM_ASSERT_IMPLIES(a_stall_only_full, clk, rst_n, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready, "input stalled with room in the pipe")

endmodule

`default_nettype wire

### sv/fhsm_mode_ctrl.sv
// Drive mode next-state logic: speed error mapping, enter/exit hysteresis, exit timer.
// Depends on fhsm_pkg.
`default_nettype none

module fhsm_mode_ctrl (
    input  wire fhsm_pkg::cfg_t        cfg,
    input  wire                        is_frame,
    input  wire logic [7:0]            speed_raw,
    input  wire fhsm_pkg::mode_state_t cur,
    output fhsm_pkg::mode_state_t      nxt,
    output logic [7:0]                 speed_kph
);
    import fhsm_pkg::*;

    assign speed_kph = (speed_raw == cfg.speed_error_code) ? 8'd0 : speed_raw;

    always_comb
    begin
        nxt = cur;
        if (is_frame)
        begin
            if (!cfg.high_speed_enable)
            begin
                nxt = '0;
            end
            else if (!cur.mode_high)
            begin
                if (speed_kph >= cfg.enter_speed_kph)
                begin
                    nxt.mode_high  = 1'b1;
                    nxt.exit_armed = 1'b0;
                    nxt.exit_timer = '0;
                end
            end
            else if (speed_kph < cfg.exit_speed_kph)
            begin
                nxt.exit_armed = 1'b1;
                if (cur.exit_timer >= cfg.exit_delay_ms)
                begin
                    nxt = '0;
                end
            end
            else
            begin
                nxt.exit_armed = 1'b0;
                nxt.exit_timer = '0;
            end
        end
        else if (cur.exit_armed && (cur.exit_timer != TIMER_MAX))
        begin
            nxt.exit_timer = cur.exit_timer + 16'd1;
        end
    end

endmodule

`default_nettype wire

### sv/fhsm_cmd_filter.sv
// Target selection, high-speed command filtering, step-start and reported position.
// Depends on fhsm_pkg; takes the already updated mode state.
`default_nettype none

module fhsm_cmd_filter (
    input  wire fhsm_pkg::cfg_t        cfg,
    input  wire                        is_frame,
    input  wire fhsm_pkg::in_item_t    item,
    input  wire fhsm_pkg::mode_state_t mode,
    input  wire fhsm_pkg::cmd_state_t  cur,
    output fhsm_pkg::cmd_state_t       nxt,
    output logic                       step_start,
    output logic [2:0]                 reported_pos
);
    import fhsm_pkg::*;

    logic       take_target;
    logic       high;
    logic       waiting;
    logic [7:0] target_wide;
    logic [2:0] target;
    logic [2:0] filt;

    assign take_target = is_frame && !item.init_busy && (cfg.unit_select != UNIT_NONE);
    assign high        = cfg.high_speed_enable && mode.mode_high;
    assign waiting     = high && mode.exit_armed;
    assign target      = target_wide[2:0];

    always_comb
    begin
        unique case (cfg.unit_select)
            UNIT_ONE:   target_wide = item.target_byte_a & UNIT_A_MASK;
            UNIT_TWO:   target_wide = (item.target_byte_a & UNIT_B_MASK) >> UNIT_B_SHIFT;
            default:    target_wide = item.target_byte_b & UNIT_A_MASK;
        endcase
    end

    always_comb
    begin
        filt = target;
        if (high)
        begin
            if (waiting)
            begin
                // hold what is there while the exit delay runs
                filt = cur.effective_cmd;
                if (item.motion_stopped && (item.current_position != POS_UNKNOWN))
                    filt = item.current_position;
                if (filt == POS_UNKNOWN)
                    filt = POS_OPEN1;
            end
            else if ((target == POS_CLOSE) || (target == POS_OPEN1))
            begin
                filt = POS_OPEN1;
            end
        end
    end

    always_comb
    begin
        step_start = 1'b0;
        if (take_target)
        begin
            if (item.motion_stopped)
                step_start = (filt != item.current_position)
                          && (item.current_position != POS_UNKNOWN)
                          && (filt != POS_UNKNOWN);
            else if (item.action_is_auto_diag)
                step_start = (filt != POS_DIAG_AUTO);
        end
    end

    always_comb
    begin
        nxt = cur;
        if (take_target)
        begin
            nxt.requested_cmd = target;
            nxt.effective_cmd = filt;
        end

        reported_pos = item.current_position;
        if (high && ((nxt.requested_cmd == POS_CLOSE) || (nxt.requested_cmd == POS_OPEN1)))
            reported_pos = nxt.requested_cmd;

        // unknown keeps the previous mark
        if (reported_pos <= POS_OPEN)
            nxt.diag_flag = 1'b0;
        else if (reported_pos <= POS_DIAG_AUTO)
            nxt.diag_flag = 1'b1;
    end

endmodule

`default_nettype wire
